[rtl/esd_pkg.sv]
// types, constants and lookup functions for the escape sequence decoder
// used by the controller, the datapath and the top level; no dependencies
package esd_pkg;

	localparam int UNIT_W     = 16;
	localparam int HOLD_DEPTH = 9;
	localparam int IDX_W      = $clog2(HOLD_DEPTH);
	localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
	localparam int HEX_W      = 32;

	localparam logic [UNIT_W-1:0] CH_BSL  = 16'h005C;
	localparam logic [UNIT_W-1:0] CH_X    = 16'h0078;
	localparam logic [UNIT_W-1:0] CH_U4   = 16'h0075;
	localparam logic [UNIT_W-1:0] CH_U8   = 16'h0055;
	localparam logic [UNIT_W-1:0] CH_ESC  = 16'h001B;
	localparam logic [UNIT_W-1:0] CH_QUES = 16'h003F;
	localparam logic [UNIT_W-1:0] CH_APOS = 16'h0027;
	localparam logic [UNIT_W-1:0] CH_QUOT = 16'h0022;
	localparam logic [HEX_W-1:0]  BMP_MAX = 32'h0000FFFF;
	localparam logic [HEX_W-1:0]  HI_BIAS = 32'h0000D7C0;
	localparam logic [5:0]        LO_TAG  = 6'b110111;

	// numeric escape flavour
	typedef enum logic [1:0] {
		HK_X,
		HK_U4,
		HK_U8
	} hex_kind_t;

	// what the unit after a backslash means
	typedef enum logic [2:0] {
		EC_MAP,
		EC_HEX_X,
		EC_HEX_U4,
		EC_HEX_U8,
		EC_OTHER
	} esc_class_t;

	// source of a unit loaded at input transfer time
	typedef enum logic [1:0] {
		OS_UNIT,
		OS_MAPPED,
		OS_BSL,
		OS_HEX
	} out_sel_t;

	// source of the first replayed unit
	typedef enum logic [1:0] {
		LS_UNIT,
		LS_MODE,
		LS_LOW
	} let_sel_t;

	// how many held digits a replay sends back
	typedef enum logic [1:0] {
		HS_NONE,
		HS_COUNT,
		HS_COUNT_INC
	} held_sel_t;

	typedef struct packed {
		logic      load_out;
		out_sel_t  out_sel;
		logic      out_last;
		logic      start_replay;
		let_sel_t  let_sel;
		held_sel_t held_sel;
		logic      tail_en;
		hex_kind_t hex_kind;
		logic      store_digit;
		logic      clr_hex;
		logic      step_replay;
	} esd_cmd_t;

	typedef struct packed {
		logic       is_bsl;
		esc_class_t esc_class;
		logic       is_hex;
		logic       hex_done;
		logic       hex_pair;
		logic       out_free;
		logic       replay_final;
	} esd_sts_t;

	function automatic esc_class_t esc_class_of(input logic [UNIT_W-1:0] c);
		esc_class_t r;
		unique case (c)
			16'h0061, 16'h0062, 16'h0065, 16'h0066,
			16'h006E, 16'h0072, 16'h0074, 16'h0076,
			CH_BSL, CH_QUES, CH_APOS, CH_QUOT: r = EC_MAP;
			CH_X:    r = EC_HEX_X;
			CH_U4:   r = EC_HEX_U4;
			CH_U8:   r = EC_HEX_U8;
			default: r = EC_OTHER;
		endcase
		return r;
	endfunction

	// control letters map to their codes, the rest pass through
	function automatic logic [UNIT_W-1:0] esc_map(input logic [UNIT_W-1:0] c);
		logic [UNIT_W-1:0] r;
		unique case (c)
			16'h0061: r = 16'h0007;
			16'h0062: r = 16'h0008;
			16'h0065: r = CH_ESC;
			16'h0066: r = 16'h000C;
			16'h006E: r = 16'h000A;
			16'h0072: r = 16'h000D;
			16'h0074: r = 16'h0009;
			16'h0076: r = 16'h000B;
			default:  r = c;
		endcase
		return r;
	endfunction

	// strict hex digit: {valid, value}
	function automatic logic [4:0] hex_val(input logic [UNIT_W-1:0] c);
		logic [4:0] r;
		priority if (c >= 16'h0030 && c <= 16'h0039)
			r = {1'b1, 4'(c - 16'h0030)};
		else if (c >= 16'h0061 && c <= 16'h0066)
			r = {1'b1, 4'(c - 16'h0057)};
		else if (c >= 16'h0041 && c <= 16'h0046)
			r = {1'b1, 4'(c - 16'h0037)};
		else
			r = 5'b0;
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] need_of(input hex_kind_t k);
		logic [CNT_W-1:0] r;
		unique case (k)
			HK_X:    r = CNT_W'(2);
			HK_U4:   r = CNT_W'(4);
			default: r = CNT_W'(8);
		endcase
		return r;
	endfunction

	function automatic logic [UNIT_W-1:0] letter_of(input hex_kind_t k);
		logic [UNIT_W-1:0] r;
		unique case (k)
			HK_X:    r = CH_X;
			HK_U4:   r = CH_U4;
			default: r = CH_U8;
		endcase
		return r;
	endfunction

endpackage

[rtl/esd_datapath.sv]
// datapath: digit store, hex accumulator, replay sequencer and output register
// depends on esd_pkg; driven by esd_ctrl through esd_cmd_t
module esd_datapath
	import esd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [UNIT_W-1:0] code_unit,
	input  logic              end_of_text,
	input  esd_cmd_t          cmd,
	output esd_sts_t          sts,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [UNIT_W-1:0] out_unit,
	output logic              out_last
);

	logic [UNIT_W-1:0] held_q [HOLD_DEPTH];
	logic [CNT_W-1:0]  held_cnt_q;
	logic [HEX_W-1:0]  hex_q;
	logic [UNIT_W-1:0] letter_q;
	logic [UNIT_W-1:0] tail_q;
	logic [CNT_W-1:0]  rep_n_q;
	logic [CNT_W-1:0]  rep_len_q;
	logic [CNT_W-1:0]  rp_q;
	logic              last_q;
	logic              out_valid_q;
	logic [UNIT_W-1:0] out_unit_q;
	logic              out_last_q;

	logic [4:0]        digit;
	logic [HEX_W-1:0]  hex_next;
	logic [CNT_W-1:0]  cnt_inc;
	logic              pair;
	logic [UNIT_W-1:0] hex_hi;
	logic [UNIT_W-1:0] hex_lo;
	logic [UNIT_W-1:0] hex_word;
	logic [CNT_W-1:0]  rd_idx;
	logic [UNIT_W-1:0] rep_unit;
	logic [UNIT_W-1:0] let_d;
	logic [CNT_W-1:0]  rep_n_d;
	logic [UNIT_W-1:0] load_unit;
	logic              load_last;

	// digit decode and accumulator update
	assign digit    = hex_val(code_unit);
	assign hex_next = {hex_q[HEX_W-5:0], digit[3:0]};
	assign cnt_inc  = CNT_W'(held_cnt_q + CNT_W'(1));
	assign pair     = (cmd.hex_kind == HK_U8) && (hex_next > BMP_MAX);

	// surrogate pair halves, truncated to a code unit
	assign hex_hi = UNIT_W'((hex_next >> 10) + HI_BIAS);
	assign hex_lo = {LO_TAG, hex_next[9:0]};

	always_comb begin
		unique case (cmd.hex_kind)
			HK_X:    hex_word = {8'h00, hex_next[7:0]};
			HK_U4:   hex_word = hex_next[UNIT_W-1:0];
			default: hex_word = pair ? hex_hi : hex_next[UNIT_W-1:0];
		endcase
	end

	// replay unit: letter, held digits, then the tail unit
	assign rd_idx = CNT_W'(rp_q - CNT_W'(1));

	always_comb begin
		if (rp_q == '0)
			rep_unit = letter_q;
		else if (rp_q <= rep_n_q)
			rep_unit = held_q[rd_idx[IDX_W-1:0]];
		else
			rep_unit = tail_q;
	end

	// replay set-up values
	always_comb begin
		unique case (cmd.let_sel)
			LS_UNIT: let_d = code_unit;
			LS_MODE: let_d = letter_of(cmd.hex_kind);
			default: let_d = hex_lo;
		endcase
		unique case (cmd.held_sel)
			HS_NONE:  rep_n_d = '0;
			HS_COUNT: rep_n_d = held_cnt_q;
			default:  rep_n_d = cnt_inc;
		endcase
	end

	// output register source
	always_comb begin
		if (cmd.step_replay) begin
			load_unit = rep_unit;
			load_last = sts.replay_final && last_q;
		end else begin
			unique case (cmd.out_sel)
				OS_UNIT:   load_unit = code_unit;
				OS_MAPPED: load_unit = esc_map(code_unit);
				OS_BSL:    load_unit = CH_BSL;
				default:   load_unit = hex_word;
			endcase
			load_last = cmd.out_last;
		end
	end

	// status towards the controller
	always_comb begin
		sts.is_bsl       = (code_unit == CH_BSL);
		sts.esc_class    = esc_class_of(code_unit);
		sts.is_hex       = digit[4];
		sts.hex_done     = (cnt_inc >= need_of(cmd.hex_kind));
		sts.hex_pair     = pair;
		sts.out_free     = !out_valid_q || !out_stall;
		sts.replay_final = (rp_q == rep_len_q);
	end

	// held digits, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.store_digit)
			held_q[held_cnt_q[IDX_W-1:0]] <= code_unit;
	end

	// digit count and accumulated value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
			hex_q      <= '0;
		end else if (cmd.clr_hex) begin
			held_cnt_q <= '0;
			hex_q      <= '0;
		end else if (cmd.store_digit) begin
			held_cnt_q <= cnt_inc;
			hex_q      <= hex_next;
		end
	end

	// replay pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rp_q <= '0;
		else if (cmd.start_replay)
			rp_q <= '0;
		else if (cmd.step_replay)
			rp_q <= CNT_W'(rp_q + CNT_W'(1));
	end

	// replay payload
	always_ff @(posedge clk) begin
		if (cmd.start_replay) begin
			letter_q  <= let_d;
			tail_q    <= code_unit;
			rep_n_q   <= rep_n_d;
			rep_len_q <= CNT_W'(rep_n_d + CNT_W'(cmd.tail_en));
			last_q    <= end_of_text;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_unit_q <= load_unit;
			out_last_q <= load_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_unit  = out_unit_q;
	assign out_last  = out_last_q;

endmodule

[rtl/esd_ctrl.sv]
// controller: decode mode state machine and replay sequencing
// depends on esd_pkg; commands esd_datapath through esd_cmd_t
module esd_ctrl
	import esd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     end_of_text,
	input  esd_sts_t sts,
	output esd_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_PLAIN,
		ST_ESC,
		ST_HEX_X,
		ST_HEX_U4,
		ST_HEX_U8,
		ST_REPLAY
	} state_t;

	state_t state_q, state_d;
	logic   resume_esc_q, resume_esc_d;
	logic   accept;

	assign in_stall = (state_q == ST_REPLAY) || !sts.out_free;
	assign accept   = in_valid && !in_stall;

	// commands and next state
	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		resume_esc_d = resume_esc_q;

		unique case (state_q)
			ST_HEX_U4: cmd.hex_kind = HK_U4;
			ST_HEX_U8: cmd.hex_kind = HK_U8;
			default:   cmd.hex_kind = HK_X;
		endcase

		unique case (state_q)
			ST_PLAIN: begin
				if (accept) begin
					if (sts.is_bsl && !end_of_text) begin
						state_d = ST_ESC;
					end else begin
						// a trailing backslash is kept as it is
						cmd.load_out = 1'b1;
						cmd.out_sel  = OS_UNIT;
						cmd.out_last = end_of_text;
					end
				end
			end
			ST_ESC: begin
				if (accept) begin
					state_d     = ST_PLAIN;
					cmd.clr_hex = 1'b1;
					unique case (sts.esc_class)
						EC_MAP: begin
							cmd.load_out = 1'b1;
							cmd.out_sel  = OS_MAPPED;
							cmd.out_last = end_of_text;
						end
						EC_HEX_X, EC_HEX_U4, EC_HEX_U8: begin
							if (end_of_text) begin
								// text ends right after the letter
								cmd.load_out     = 1'b1;
								cmd.out_sel      = OS_BSL;
								cmd.start_replay = 1'b1;
								cmd.let_sel      = LS_UNIT;
								cmd.held_sel     = HS_NONE;
								state_d          = ST_REPLAY;
								resume_esc_d     = 1'b0;
							end else begin
								unique case (sts.esc_class)
									EC_HEX_X:  state_d = ST_HEX_X;
									EC_HEX_U4: state_d = ST_HEX_U4;
									default:   state_d = ST_HEX_U8;
								endcase
							end
						end
						default: begin
							// unknown letter goes out literally
							cmd.load_out     = 1'b1;
							cmd.out_sel      = OS_BSL;
							cmd.start_replay = 1'b1;
							cmd.let_sel      = LS_UNIT;
							cmd.held_sel     = HS_NONE;
							state_d          = ST_REPLAY;
							resume_esc_d     = 1'b0;
						end
					endcase
				end
			end
			ST_HEX_X, ST_HEX_U4, ST_HEX_U8: begin
				if (accept) begin
					if (sts.is_hex) begin
						cmd.store_digit = 1'b1;
						if (sts.hex_done) begin
							// escape complete: one unit or a surrogate pair
							cmd.clr_hex  = 1'b1;
							cmd.load_out = 1'b1;
							cmd.out_sel  = OS_HEX;
							cmd.out_last = end_of_text && !sts.hex_pair;
							if (sts.hex_pair) begin
								cmd.start_replay = 1'b1;
								cmd.let_sel      = LS_LOW;
								cmd.held_sel     = HS_NONE;
								state_d          = ST_REPLAY;
								resume_esc_d     = 1'b0;
							end else begin
								state_d = ST_PLAIN;
							end
						end else if (end_of_text) begin
							// too few digits before the end of text
							cmd.clr_hex      = 1'b1;
							cmd.load_out     = 1'b1;
							cmd.out_sel      = OS_BSL;
							cmd.start_replay = 1'b1;
							cmd.let_sel      = LS_MODE;
							cmd.held_sel     = HS_COUNT_INC;
							state_d          = ST_REPLAY;
							resume_esc_d     = 1'b0;
						end
					end else begin
						// non-hex unit: replay, then decode it afresh
						cmd.clr_hex      = 1'b1;
						cmd.load_out     = 1'b1;
						cmd.out_sel      = OS_BSL;
						cmd.start_replay = 1'b1;
						cmd.let_sel      = LS_MODE;
						cmd.held_sel     = HS_COUNT;
						cmd.tail_en      = !sts.is_bsl || end_of_text;
						state_d          = ST_REPLAY;
						resume_esc_d     = sts.is_bsl && !end_of_text;
					end
				end
			end
			ST_REPLAY: begin
				if (sts.out_free) begin
					cmd.load_out    = 1'b1;
					cmd.step_replay = 1'b1;
					if (sts.replay_final)
						state_d = resume_esc_q ? ST_ESC : ST_PLAIN;
				end
			end
			default: begin
				state_d = ST_PLAIN;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_PLAIN;
			resume_esc_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			resume_esc_q <= resume_esc_d;
		end
	end

endmodule

[rtl/escape_sequence_decoder_core.sv]
// top level of the backslash escape decoder for UTF-16 text
// depends on esd_pkg, esd_ctrl and esd_datapath
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------
//  input   | in        | in_valid, in_stall | code_unit, end_of_text
//  output  | out       | out_valid, out_stall | out_unit, out_last
//
// one code unit is taken per cycle while out_stall is low and each unit
// gives at most one result; a unit with more (failed escape or surrogate
// pair) stalls the input: the first result loads with the transfer, the
// rest replay one a cycle unless stalled, via the single output register
// reset clears mode, digit count and value; the digit store is not cleared
// out_stall holds the output register and, through it, stalls the input
module escape_sequence_decoder_core
	import esd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [UNIT_W-1:0] code_unit,
	input  logic              end_of_text,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [UNIT_W-1:0] out_unit,
	output logic              out_last
);

	esd_cmd_t cmd;
	esd_sts_t sts;

	// controller
	esd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.end_of_text (end_of_text),
		.sts         (sts),
		.cmd         (cmd)
	);

	// datapath
	esd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.code_unit   (code_unit),
		.end_of_text (end_of_text),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_unit    (out_unit),
		.out_last    (out_last)
	);

endmodule

[rtl/esd_checker.sv]
// port-level assertions for the escape sequence decoder
// depends on esd_pkg; bound to escape_sequence_decoder_core
module esd_checker
	import esd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [UNIT_W-1:0] code_unit,
	input logic              end_of_text,
	input logic              out_valid,
	input logic              out_stall,
	input logic [UNIT_W-1:0] out_unit,
	input logic              out_last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_unit) && $stable(out_last))
		else $error("stalled result changed");

	// a stalled input transfer keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(code_unit) && $stable(end_of_text))
		else $error("stalled input changed");

	// the final unit of a text always gives a result at once
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && end_of_text |=> out_valid)
		else $error("end of text gave no result");

	// once the final result goes, nothing is held back
	a_last_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_last |-> !in_stall)
		else $error("input stalled at end of text");

	// leaving reset the block is empty and ready
	a_reset_clean: assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> !out_valid && !in_stall)
		else $error("block not empty after reset");

endmodule

bind escape_sequence_decoder_core esd_checker u_esd_checker (.*);
